>>> rtl/twgt_pkg.sv
// twgt_pkg: types, constants and arithmetic helpers of the twiddle gain tuner
// used by twiddle_gain_tuner_unit; depends on nothing else
package twgt_pkg;

  localparam int unsigned GainW  = 31;
  localparam int unsigned ErrW   = 48;
  localparam int unsigned CoordW = 2;
  localparam int unsigned QuotW  = 28;   // a 31-bit value over ten fits in 28 bits
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OutDataW = 152;

  typedef logic [GainW-1:0] gain_t;
  typedef logic [2:0][GainW-1:0] triple_t;

  // one-hot tuner phase
  typedef enum logic [2:0] {
    PH_START = 3'b001,
    PH_UP    = 3'b010,
    PH_DOWN  = 3'b100
  } phase_e;

  // phase codes shown on the result
  localparam logic [1:0] PHASE_CODE_START = 2'd0;
  localparam logic [1:0] PHASE_CODE_UP    = 2'd1;
  localparam logic [1:0] PHASE_CODE_DOWN  = 2'd2;

  localparam logic [CoordW-1:0] COORD_P = 2'd0;
  localparam logic [CoordW-1:0] COORD_D = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_GAIN_P = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_GAIN_I = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_GAIN_D = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_STEP_P = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_START_STEP_I = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_START_STEP_D = 3'd5;

  localparam triple_t GAIN_RST = {31'd50331648, 31'd16777, 31'd1929380};
  localparam triple_t STEP_RST = {31'd838861, 31'd16777, 31'd838861};
  localparam logic [ErrW-1:0] BEST_RST = 48'd167772160000;  // 10000 in q24.24

  localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;  // 2^35 / 10, rounded up
  localparam gain_t GAIN_MAX = 31'h7FFFFFFF;

  function automatic gain_t sat_add(input gain_t a, input gain_t b);
    logic [GainW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[GainW] ? GAIN_MAX : s[GainW-1:0];
  endfunction

  // exact floor(v / 10) for any 31-bit v
  function automatic logic [QuotW-1:0] div_ten(input gain_t v);
    logic [62:0] p;
    p = 63'(v) * 63'(RECIP_TEN);
    return p[62:35];
  endfunction

  function automatic logic [CoordW-1:0] next_coord(input logic [CoordW-1:0] c);
    return (c >= COORD_D) ? COORD_P : c + 2'd1;
  endfunction

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] code;
    case (ph)
      PH_START: code = PHASE_CODE_START;
      PH_UP:    code = PHASE_CODE_UP;
      default:  code = PHASE_CODE_DOWN;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/twiddle_gain_tuner_unit.sv
// twiddle_gain_tuner_unit: three-phase coordinate-descent tuner of p, i, d gains
// depends on twgt_pkg for types, reset values and the divide-by-ten helper
// an accepted item waits in the input register; its result is held in the result register
// throughput: one item per cycle while the result is taken; the single update stage (one shared
//   31x32 reciprocal multiply for the 1.1 / 0.9 scaling) sets the pace
// reset: start registers, gains and steps take their default values, best error
//   is 10000, coord is zero, phase is start, both pipeline stages empty
module twiddle_gain_tuner_unit
  import twgt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [GainW-1:0]    cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ErrW-1:0]     s_axis_tdata,   // error_value
  input  logic                s_axis_tuser,   // restart
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // gain_p, gain_i, gain_d, best_seen, gain_index, phase_now, zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  // start registers
  triple_t cfg_gain_q, cfg_step_q;

  // tuner state
  triple_t gains_q, gains_d;
  triple_t steps_q, steps_d;
  logic [ErrW-1:0] best_q, best_d;
  logic [CoordW-1:0] coord_q, coord_d;
  phase_e phase_q, phase_d;

  // input stage
  logic            in_vld_q;
  logic [ErrW-1:0] in_err_q;
  logic            in_restart_q;

  // result stage
  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q;

  logic adv;
  assign adv = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_gain_q <= GAIN_RST;
      cfg_step_q <= STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_GAIN_P: cfg_gain_q[0] <= cfg_data_i;
        CFG_START_GAIN_I: cfg_gain_q[1] <= cfg_data_i;
        CFG_START_GAIN_D: cfg_gain_q[2] <= cfg_data_i;
        CFG_START_STEP_P: cfg_step_q[0] <= cfg_data_i;
        CFG_START_STEP_I: cfg_step_q[1] <= cfg_data_i;
        CFG_START_STEP_D: cfg_step_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_err_q     <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  // update logic
  logic [CoordW-1:0] c, cn;
  gain_t g_c, s_c, g_cn, s_cn;
  gain_t sum_c, sum_cn;
  gain_t op;
  logic [QuotW-1:0] quo;
  logic [GainW:0] up_sum;
  gain_t up11, dn9, tenq;
  logic [GainW:0] twice;
  logic better;

  always_comb begin
    c      = coord_q;
    cn     = next_coord(coord_q);
    g_c    = gains_q[c];
    s_c    = steps_q[c];
    g_cn   = gains_q[cn];
    s_cn   = steps_q[cn];
    sum_c  = sat_add(g_c, s_c);
    sum_cn = sat_add(g_cn, s_cn);
    // probe-up success scales the gain, the down judgment scales the step
    op     = (phase_q == PH_UP) ? g_c : s_c;
    quo    = div_ten(op);
    up_sum = {1'b0, op} + 32'(quo);
    up11   = up_sum[GainW] ? GAIN_MAX : up_sum[GainW-1:0];
    tenq   = 31'({quo, 3'b000}) + 31'({quo, 1'b0});
    // floor(0.9 v) = v - ceil(v / 10)
    dn9    = op - 31'(quo) - 31'(op != tenq);
    twice  = {s_c, 1'b0};
    better = $signed(in_err_q) < $signed(best_q);
  end

  always_comb begin
    gains_d = gains_q;
    steps_d = steps_q;
    best_d  = best_q;
    coord_d = coord_q;
    phase_d = phase_q;
    if (in_restart_q) begin
      gains_d = cfg_gain_q;
      steps_d = cfg_step_q;
      coord_d = COORD_P;
      phase_d = PH_START;
    end else begin
      case (phase_q)
        PH_START: begin
          gains_d[c] = sum_c;
          best_d     = in_err_q;
          phase_d    = PH_UP;
        end
        PH_UP: begin
          if (better) begin
            best_d      = in_err_q;
            gains_d[c]  = up11;
            gains_d[cn] = sum_cn;
            coord_d     = cn;
          end else begin
            // clamp at zero and move on when the down probe would go negative
            if (twice > {1'b0, g_c}) begin
              gains_d[c] = '0;
              coord_d    = cn;
            end else begin
              gains_d[c] = g_c - twice[GainW-1:0];
            end
            phase_d = PH_DOWN;
          end
        end
        default: begin
          if (better) begin
            best_d     = in_err_q;
            steps_d[c] = up11;
          end else begin
            gains_d[c] = sum_c;
            steps_d[c] = dn9;
          end
          gains_d[cn] = sum_cn;
          coord_d     = cn;
          phase_d     = PH_UP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= GAIN_RST;
      steps_q <= STEP_RST;
      best_q  <= BEST_RST;
      coord_q <= COORD_P;
      phase_q <= PH_START;
    end else if (adv) begin
      gains_q <= gains_d;
      steps_q <= steps_d;
      best_q  <= best_d;
      coord_q <= coord_d;
      phase_q <= phase_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {7'b0, phase_code(phase_d), coord_d, best_d,
                     gains_d[2], gains_d[1], gains_d[0]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coord_q != 2'd3)
    else $error("coord out of range");

  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_restart_q |=> out_data_q[142:141] == COORD_P &&
      out_data_q[144:143] == PHASE_CODE_START && phase_q == PH_START)
    else $error("restart did not return to start phase and first gain");

  a_start_sets_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !in_restart_q && phase_q == PH_START |=> best_q == $past(in_err_q))
    else $error("start phase did not record best error");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_err_q) && $stable(in_restart_q))
    else $error("input stage lost a waiting beat");

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(gains_q) && $stable(steps_q) && $stable(best_q))
    else $error("tuner state changed without an update");

endmodule

>>> bench/twiddle_gain_tuner_unit_tb.sv
// twiddle_gain_tuner_unit_tb: self-checking bench for the twiddle gain tuner, with a
// queue-fed stream driver, a predictor of gains, steps and best error, and a checking monitor
// depends on twgt_pkg and twiddle_gain_tuner_unit
module twiddle_gain_tuner_unit_tb;
  import twgt_pkg::*;

  localparam int NumSettings  = 5;
  localparam int BeatsPerSet  = 172;
  localparam int HoldAtBeat   = 250;
  localparam int HoldCycles   = 400;
  localparam int MaxShown     = 10;

  // indexes past the six registers, the block must ignore them
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [CfgIdxW-1:0] REG_ORDER [6] = '{
    CFG_START_GAIN_P, CFG_START_GAIN_I, CFG_START_GAIN_D,
    CFG_START_STEP_P, CFG_START_STEP_I, CFG_START_STEP_D
  };

  localparam logic signed [ErrW-1:0] ERR_TOP = {1'b0, {(ErrW-1){1'b1}}};
  localparam logic signed [ErrW-1:0] ERR_BOT = {1'b1, {(ErrW-1){1'b0}}};

  typedef struct packed {
    logic                 restart;
    logic [ErrW-1:0]      error_value;
  } eval_beat_t;

  typedef struct packed {
    logic [6:0]           fill;
    logic [1:0]           phase_now;
    logic [CoordW-1:0]    gain_index;
    logic [ErrW-1:0]      best_seen;
    gain_t                gain_d;
    gain_t                gain_i;
    gain_t                gain_p;
  } tuner_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [GainW-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ErrW-1:0]     s_axis_tdata = '0;  // error_value
  logic                s_axis_tuser = 1'b0;  // restart
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // gain_p, gain_i, gain_d, best_seen, gain_index, phase_now, zero fill
  logic [OutDataW-1:0] m_axis_tdata;

  twiddle_gain_tuner_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // tuner state as the bench expects it
  logic [63:0]              tuned_gain [3];
  logic [63:0]              tuned_step [3];
  logic [GainW-1:0]         start_regs [6];
  logic signed [ErrW-1:0]   best_err;
  logic [CoordW-1:0]        tuned_coord;
  logic [1:0]               tuned_phase;

  eval_beat_t     pending_beats [$];
  tuner_result_t  expected_gains_q [$];
  eval_beat_t     launch_beat;

  int  beats_in = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  restarts_sent = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  calm = 1'b0;

  function automatic logic [63:0] clamp_q(input logic [63:0] v);
    return (v > 64'(GAIN_MAX)) ? 64'(GAIN_MAX) : v;
  endfunction

  function automatic logic [63:0] scale_tenths(input logic [63:0] v, input int unsigned num);
    return clamp_q((v * 64'(num)) / 64'd10);
  endfunction

  function automatic logic [CoordW-1:0] following_coord(input logic [CoordW-1:0] c);
    return (c >= COORD_D) ? COORD_P : c + 2'd1;
  endfunction

  function automatic void load_start_values();
    for (int k = 0; k < 3; k++) begin
      tuned_gain[k] = 64'(start_regs[k]);
      tuned_step[k] = 64'(start_regs[k+3]);
    end
    tuned_coord = COORD_P;
    tuned_phase = PHASE_CODE_START;
  endfunction

  // one evaluation: advance the twiddle machine and return the gains it leaves
  function automatic tuner_result_t tune_step(input eval_beat_t b);
    logic [CoordW-1:0]      c;
    logic signed [ErrW-1:0] err;
    logic [63:0]            twice;
    tuner_result_t          r;
    c = tuned_coord;
    err = signed'(b.error_value);
    if (b.restart) begin
      load_start_values();
    end else begin
      case (tuned_phase)
        PHASE_CODE_START: begin
          tuned_gain[c] = clamp_q(tuned_gain[c] + tuned_step[c]);
          best_err = err;
          tuned_phase = PHASE_CODE_UP;
        end
        PHASE_CODE_UP: begin
          if (err < best_err) begin
            best_err = err;
            tuned_gain[c] = scale_tenths(tuned_gain[c], 11);
            c = following_coord(c);
            tuned_gain[c] = clamp_q(tuned_gain[c] + tuned_step[c]);
          end else begin
            twice = tuned_step[c] * 64'd2;
            // probe below zero clamps and moves on, an exact zero stays
            if (twice > tuned_gain[c]) begin
              tuned_gain[c] = '0;
              c = following_coord(c);
            end else begin
              tuned_gain[c] = tuned_gain[c] - twice;
            end
            tuned_phase = PHASE_CODE_DOWN;
          end
          tuned_coord = c;
        end
        default: begin
          if (err < best_err) begin
            best_err = err;
            tuned_step[c] = scale_tenths(tuned_step[c], 11);
          end else begin
            tuned_gain[c] = clamp_q(tuned_gain[c] + tuned_step[c]);
            tuned_step[c] = scale_tenths(tuned_step[c], 9);
          end
          c = following_coord(c);
          tuned_gain[c] = clamp_q(tuned_gain[c] + tuned_step[c]);
          tuned_coord = c;
          tuned_phase = PHASE_CODE_UP;
        end
      endcase
    end
    r.fill = '0;
    r.phase_now = tuned_phase;
    r.gain_index = tuned_coord;
    r.best_seen = best_err;
    r.gain_p = tuned_gain[0][GainW-1:0];
    r.gain_i = tuned_gain[1][GainW-1:0];
    r.gain_d = tuned_gain[2][GainW-1:0];
    return r;
  endfunction

  // driver: launches queued beats, random gaps between them
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_gains_q.push_back(tune_step({s_axis_tuser, s_axis_tdata}));
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          launch_beat = pending_beats.pop_front();
          s_axis_tdata <= launch_beat.error_value;
          s_axis_tuser <= launch_beat.restart;
          s_axis_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat, stalls at random and once for a long stretch
  always @(posedge clk_i) begin
    tuner_result_t got;
    tuner_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (expected_gains_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown) $display("result beat %0d arrived with nothing expected",
                                               results_seen);
        end else begin
          want = expected_gains_q.pop_front();
          if (got.gain_p !== want.gain_p || got.gain_i !== want.gain_i ||
              got.gain_d !== want.gain_d || got.best_seen !== want.best_seen ||
              got.gain_index !== want.gain_index || got.phase_now !== want.phase_now ||
              got.fill !== want.fill) begin
            mismatches++;
            if (mismatches <= MaxShown) begin
              $display("beat %0d expected p=%h i=%h d=%h best=%h idx=%0d ph=%0d fill=%h",
                       results_seen, want.gain_p, want.gain_i, want.gain_d, want.best_seen,
                       want.gain_index, want.phase_now, want.fill);
              $display("beat %0d actual   p=%h i=%h d=%h best=%h idx=%0d ph=%0d fill=%h",
                       results_seen, got.gain_p, got.gain_i, got.gain_d, got.best_seen,
                       got.gain_index, got.phase_now, got.fill);
            end
          end
        end
      end
      if (!hold_done && beats_in >= HoldAtBeat) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 15);
      end
    end
  end

  task automatic queue_beat(input logic [ErrW-1:0] err, input logic rs);
    eval_beat_t b;
    b.error_value = err;
    b.restart = rs;
    if (rs) restarts_sent++;
    pending_beats.push_back(b);
  endtask

  // sender holds off until every result is back and the pipeline is empty
  task automatic wait_drain();
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_gains_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx < CFG_SPARE_LO) start_regs[idx] = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [GainW-1:0] pick_reg_value();
    logic [GainW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = GainW'($urandom_range(0, 2000));
      1: v = GainW'($urandom);
      2: v = GAIN_MAX;
      default: v = GainW'($urandom_range(0, 32'h0400_0000));
    endcase
    return v;
  endfunction

  initial begin
    logic signed [ErrW-1:0] trend;
    logic signed [ErrW-1:0] err;
    int                     tmp;
    for (int k = 0; k < 3; k++) begin
      start_regs[k] = GAIN_RST[k];
      start_regs[k+3] = STEP_RST[k];
    end
    load_start_values();
    best_err = signed'(BEST_RST);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: improve, tie, exact zero on the way down, error extremes, restart
    queue_beat(48'sd100, 1'b0);
    queue_beat(48'sd50, 1'b0);
    queue_beat(48'sd50, 1'b0);
    queue_beat(48'sd49, 1'b0);
    queue_beat(ERR_TOP, 1'b0);
    queue_beat(ERR_BOT, 1'b0);
    queue_beat(ERR_BOT, 1'b0);
    queue_beat(48'sd0, 1'b0);
    queue_beat(-48'sd1, 1'b0);
    queue_beat(ERR_TOP, 1'b1);
    queue_beat(48'sd7, 1'b0);
    queue_beat(48'sd6, 1'b0);
    queue_beat(48'sd6, 1'b0);
    wait_drain();

    // everything at the top: saturation of sums and products
    for (int k = 0; k < 6; k++) write_reg(REG_ORDER[k], GAIN_MAX);
    write_reg(CFG_SPARE_LO, '0);
    write_reg(CFG_SPARE_HI, 31'h1234);
    @(negedge clk_i);
    queue_beat(ERR_BOT, 1'b1);
    queue_beat(48'sd3, 1'b0);
    queue_beat(48'sd3, 1'b0);
    queue_beat(48'sd2, 1'b0);
    queue_beat(48'sd1, 1'b0);
    queue_beat(48'sd1, 1'b0);
    wait_drain();

    // small gain with a large step: downward probe goes below zero
    write_reg(CFG_START_GAIN_P, 31'd5);
    write_reg(CFG_START_GAIN_I, 31'd0);
    write_reg(CFG_START_GAIN_D, 31'd100);
    write_reg(CFG_START_STEP_P, 31'd10);
    write_reg(CFG_START_STEP_I, 31'd0);
    write_reg(CFG_START_STEP_D, 31'd50);
    @(negedge clk_i);
    queue_beat(48'sd0, 1'b1);
    queue_beat(48'sd10, 1'b0);
    queue_beat(48'sd10, 1'b0);
    queue_beat(48'sd9, 1'b0);
    queue_beat(48'sd9, 1'b0);
    queue_beat(48'sd9, 1'b0);
    wait_drain();

    for (int s = 0; s < NumSettings; s++) begin
      for (int k = 0; k < 6; k++) write_reg(REG_ORDER[k], (s == 0) ? '0 : pick_reg_value());
      @(negedge clk_i);
      if (s == NumSettings - 1) calm = 1'b1;
      trend = ErrW'($urandom_range(0, 100000));
      queue_beat(ErrW'({$urandom, $urandom}), 1'b1);
      for (int n = 0; n < BeatsPerSet; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // slowly falling error: runs of improvements with ties mixed in
            trend = trend - ErrW'($urandom_range(0, 2));
            err = trend;
          end
          4, 5, 6: begin
            tmp = $urandom_range(0, 8) - 4;
            err = ErrW'(tmp);
          end
          default: err = ErrW'({$urandom, $urandom});
        endcase
        queue_beat(err, $urandom_range(0, 59) == 0);
      end
      wait_drain();
    end

    repeat (10) @(posedge clk_i);
    $display("sent %0d beats over %0d register settings with %0d restarts", beats_in,
             NumSettings + 3, restarts_sent);
    $display("checked %0d result beats, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_gains_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", expected_gains_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
